// ===== src/qrs_pkg.sv =====
package qrs_pkg;

  // Fixed-point format and the widths that follow from it.
  localparam int FracBits = 16;
  localparam int CoefW    = 16;
  localparam int RootW    = 34;
  localparam int DiscW    = 2 * CoefW + 3;          // signed b*b - 4*a*c
  localparam int RadW     = 2 * CoefW + 2;          // nonnegative discriminant, even width
  localparam int SqSteps  = RadW / 2 + FracBits;    // one root bit per stage
  localparam int RemW     = SqSteps + 3;            // square root remainder
  localparam int NumW     = CoefW + FracBits + 1;   // -b or -c scaled, signed
  localparam int DenW     = CoefW + 2;              // 2a or b, signed
  localparam int DmW      = CoefW + 1;              // divisor magnitude
  localparam int QW       = SqSteps + 2;            // dividend and quotient magnitude
  localparam int SumW     = QW + 1;                 // signed dividend
  localparam int InW      = 3 * CoefW;
  localparam int InBytesW = ((InW + 7) / 8) * 8;
  localparam int OutW     = 3 + 2 * RootW;
  localparam int OutBytesW = ((OutW + 7) / 8) * 8;

  typedef enum logic [2:0] {
    KindInfinite = 3'd0,
    KindNone     = 3'd1,
    KindLinear   = 3'd2,
    KindDouble   = 3'd3,
    KindTwo      = 3'd4
  } kind_e;

  // Product stage.
  typedef struct packed {
    logic [CoefW-1:0]   a;
    logic [CoefW-1:0]   b;
    logic [CoefW-1:0]   c;
    logic [2*CoefW-1:0] bb;
    logic [2*CoefW-1:0] ac;
  } mul_t;

  // Classification and square root stages.
  typedef struct packed {
    kind_e              kind;
    logic [NumW-1:0]    n;
    logic [DenW-1:0]    den;
    logic [RadW-1:0]    rad;
    logic [RemW-1:0]    rem;
    logic [SqSteps-1:0] root;
  } sq_t;

  // Divider stages, both branches side by side.
  typedef struct packed {
    kind_e          kind;
    logic           neg_p;
    logic           neg_m;
    logic [DmW-1:0] dmag;
    logic [QW-1:0]  qp;
    logic [QW-1:0]  qm;
    logic [DmW:0]   rp;
    logic [DmW:0]   rm;
  } dv_t;

  typedef struct packed {
    kind_e            kind;
    logic [RootW-1:0] r1;
    logic [RootW-1:0] r2;
  } res_t;

endpackage

// ===== src/quadratic_root_solver.sv =====
// Quadratic root solver: each request carries coefficients a, b, c and yields one result
// with the root kind and two roots in signed fixed point with 16 fraction bits. The block
// is a fully pipelined datapath: one product stage, one classification stage, 33 square
// root stages (one root bit each), one numerator stage and 35 restoring divider stages
// (one quotient bit each), and a new request is taken every cycle while the pipeline is
// not held. A two-entry output queue lets requests keep entering while a result waits;
// the whole pipeline holds only when that queue is full and not drained.
module quadratic_root_solver (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // coef_a [15:0], coef_b [31:16], coef_c [47:32]
  input  logic [qrs_pkg::InBytesW-1:0]         s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // root_kind [2:0], root_first [36:3], root_second [70:37], zero [71]
  output logic [qrs_pkg::OutBytesW-1:0]        m_axis_tdata
);

  localparam int CW = qrs_pkg::CoefW;
  localparam int NSq = qrs_pkg::SqSteps + 1;
  localparam int NDv = qrs_pkg::QW;

  logic                en;
  logic                mul_v_q;
  qrs_pkg::mul_t       mul_q;
  qrs_pkg::sq_t        cls_d;
  logic [NSq-1:0]      sq_v_q;
  qrs_pkg::sq_t        sq_q [NSq];
  qrs_pkg::sq_t        sq_d [NSq];
  qrs_pkg::dv_t        num_d;
  logic [NDv:0]        dv_v_q;
  qrs_pkg::dv_t        dv_q [NDv+1];
  qrs_pkg::dv_t        dv_d [NDv+1];
  qrs_pkg::res_t       res;
  qrs_pkg::res_t       fifo_q [2];
  logic [1:0]          cnt_q;
  logic                wr_q, rd_q;
  logic                push, pop;

  // The pipeline moves whenever the output queue can take another result.
  assign pop  = m_axis_tvalid && m_axis_tready;
  assign en   = (cnt_q != 2'd2) || m_axis_tready;
  assign push = en && dv_v_q[NDv];
  assign s_axis_tready = en;

  // Product stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_v_q <= 1'b0;
    end else if (en) begin
      mul_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mul_q.a  <= s_axis_tdata[CW-1:0];
      mul_q.b  <= s_axis_tdata[2*CW-1:CW];
      mul_q.c  <= s_axis_tdata[3*CW-1:2*CW];
      mul_q.bb <= (2*CW)'($signed(s_axis_tdata[2*CW-1:CW]) * $signed(s_axis_tdata[2*CW-1:CW]));
      mul_q.ac <= (2*CW)'($signed(s_axis_tdata[CW-1:0]) * $signed(s_axis_tdata[3*CW-1:2*CW]));
    end
  end

  // Classification: discriminant, kind, numerator base and divisor.
  always_comb begin
    logic [qrs_pkg::DiscW-1:0] disc;
    logic [qrs_pkg::NumW-1:0]  nb, nc;
    disc = {{3{mul_q.bb[2*CW-1]}}, mul_q.bb} - {mul_q.ac[2*CW-1], mul_q.ac, 2'b00};
    nb = qrs_pkg::NumW'(0) - {mul_q.b[CW-1], mul_q.b, qrs_pkg::FracBits'(0)};
    nc = qrs_pkg::NumW'(0) - {mul_q.c[CW-1], mul_q.c, qrs_pkg::FracBits'(0)};
    cls_d = '0;
    if (mul_q.a == '0) begin
      cls_d.n   = nc;
      cls_d.den = {{2{mul_q.b[CW-1]}}, mul_q.b};
      if (mul_q.b != '0) begin
        cls_d.kind = qrs_pkg::KindLinear;
      end else if (mul_q.c == '0) begin
        cls_d.kind = qrs_pkg::KindInfinite;
      end else begin
        cls_d.kind = qrs_pkg::KindNone;
      end
    end else begin
      cls_d.n   = nb;
      cls_d.den = {mul_q.a[CW-1], mul_q.a, 1'b0};
      if (disc[qrs_pkg::DiscW-1]) begin
        cls_d.kind = qrs_pkg::KindNone;
      end else if (disc == '0) begin
        cls_d.kind = qrs_pkg::KindDouble;
      end else begin
        cls_d.kind = qrs_pkg::KindTwo;
        cls_d.rad  = disc[qrs_pkg::RadW-1:0];
      end
    end
  end

  // Square root stages, one root bit each.
  always_comb begin
    logic [qrs_pkg::RemW-1:0] remx, trial;
    sq_d[0] = cls_d;
    for (int k = 1; k < NSq; k++) begin
      sq_d[k] = sq_q[k-1];
      remx  = {sq_q[k-1].rem[qrs_pkg::RemW-3:0], sq_q[k-1].rad[qrs_pkg::RadW-1 -: 2]};
      trial = {1'b0, sq_q[k-1].root, 2'b01};
      sq_d[k].rad = {sq_q[k-1].rad[qrs_pkg::RadW-3:0], 2'b00};
      if (remx >= trial) begin
        sq_d[k].rem  = remx - trial;
        sq_d[k].root = {sq_q[k-1].root[qrs_pkg::SqSteps-2:0], 1'b1};
      end else begin
        sq_d[k].rem  = remx;
        sq_d[k].root = {sq_q[k-1].root[qrs_pkg::SqSteps-2:0], 1'b0};
      end
    end
  end

  // Numerator stage: both branches, split into sign and magnitude.
  always_comb begin
    logic [qrs_pkg::SumW-1:0] np, nm, nx, sx;
    logic [qrs_pkg::DenW-1:0] dabs;
    qrs_pkg::sq_t             s;
    s  = sq_q[NSq-1];
    nx = {{(qrs_pkg::SumW-qrs_pkg::NumW){s.n[qrs_pkg::NumW-1]}}, s.n};
    sx = {{(qrs_pkg::SumW-qrs_pkg::SqSteps){1'b0}}, s.root};
    np = nx + sx;
    nm = nx - sx;
    dabs = s.den[qrs_pkg::DenW-1] ? qrs_pkg::DenW'(0) - s.den : s.den;
    num_d       = '0;
    num_d.kind  = s.kind;
    num_d.dmag  = dabs[qrs_pkg::DmW-1:0];
    num_d.neg_p = np[qrs_pkg::SumW-1] ^ s.den[qrs_pkg::DenW-1];
    num_d.neg_m = nm[qrs_pkg::SumW-1] ^ s.den[qrs_pkg::DenW-1];
    num_d.qp = np[qrs_pkg::SumW-1] ? qrs_pkg::QW'(qrs_pkg::SumW'(0) - np) : np[qrs_pkg::QW-1:0];
    num_d.qm = nm[qrs_pkg::SumW-1] ? qrs_pkg::QW'(qrs_pkg::SumW'(0) - nm) : nm[qrs_pkg::QW-1:0];
  end

  // Restoring divider stages: the dividend shifts out as the quotient shifts in.
  always_comb begin
    logic [qrs_pkg::DmW:0] tp, tm, dx;
    dv_d[0] = num_d;
    for (int k = 1; k <= NDv; k++) begin
      dv_d[k] = dv_q[k-1];
      dx = {1'b0, dv_q[k-1].dmag};
      tp = {dv_q[k-1].rp[qrs_pkg::DmW-1:0], dv_q[k-1].qp[qrs_pkg::QW-1]};
      tm = {dv_q[k-1].rm[qrs_pkg::DmW-1:0], dv_q[k-1].qm[qrs_pkg::QW-1]};
      dv_d[k].qp = {dv_q[k-1].qp[qrs_pkg::QW-2:0], tp >= dx};
      dv_d[k].qm = {dv_q[k-1].qm[qrs_pkg::QW-2:0], tm >= dx};
      dv_d[k].rp = (tp >= dx) ? tp - dx : tp;
      dv_d[k].rm = (tm >= dx) ? tm - dx : tm;
    end
  end

  // Stage registers for the root and divider sections.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q <= '0;
      dv_v_q <= '0;
    end else if (en) begin
      sq_v_q <= {sq_v_q[NSq-2:0], mul_v_q};
      dv_v_q <= {dv_v_q[NDv-1:0], sq_v_q[NSq-1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NSq; k++) begin
        sq_q[k] <= sq_d[k];
      end
      for (int k = 0; k <= NDv; k++) begin
        dv_q[k] <= dv_d[k];
      end
    end
  end

  // Sign correction and masking of roots that do not exist.
  always_comb begin
    logic [qrs_pkg::SumW-1:0] up, um;
    up = {1'b0, dv_q[NDv].qp};
    um = {1'b0, dv_q[NDv].qm};
    if (dv_q[NDv].neg_p) up = qrs_pkg::SumW'(0) - up;
    if (dv_q[NDv].neg_m) um = qrs_pkg::SumW'(0) - um;
    res.kind = dv_q[NDv].kind;
    if (dv_q[NDv].kind == qrs_pkg::KindInfinite || dv_q[NDv].kind == qrs_pkg::KindNone) begin
      res.r1 = '0;
      res.r2 = '0;
    end else begin
      res.r1 = up[qrs_pkg::RootW-1:0];
      res.r2 = um[qrs_pkg::RootW-1:0];
    end
  end

  // Two-entry output queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= res;
    end
  end

  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = {{(qrs_pkg::OutBytesW-qrs_pkg::OutW){1'b0}},
                          fifo_q[rd_q].r2, fifo_q[rd_q].r1, fifo_q[rd_q].kind};

`ifndef NO_ASSERTIONS
  // A blocked input means the output queue really holds a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !s_axis_tready |-> m_axis_tvalid)
    else $error("input blocked with empty output queue");
  // The queue never overflows.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("output queue overflow");
  // Equations without roots report zero roots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && (res.kind == qrs_pkg::KindInfinite || res.kind == qrs_pkg::KindNone)
      |-> res.r1 == '0 && res.r2 == '0)
    else $error("nonzero root for rootless equation");
  // Single and double roots give equal branches.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && (res.kind == qrs_pkg::KindLinear || res.kind == qrs_pkg::KindDouble)
      |-> res.r1 == res.r2)
    else $error("branches differ for a single root");
`endif

endmodule
